### hw/rtl/lflpr_pkg.sv
// shared types and constants of the local fifo/lru page replacer
package lflpr_pkg;

  localparam int unsigned QUOTA_W  = 7;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned FAULT_W  = 32;
  localparam int unsigned FIDX_W   = 6;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic CMD_REF   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_PROCESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE        = 1'b1;

  localparam logic [QUOTA_W-1:0] QUOTA_RESET = 7'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lflpr_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic commit;
  } lflpr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic scan_done;
    logic rd_pend;
    logic out_free;
  } lflpr_sts_t;

endpackage

### hw/rtl/lflpr_ram.sv
// generic single-write, single-read ram with registered read data
module lflpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lflpr_ctrl.sv
// sequencing state machine: accept, table scan, commit
module lflpr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lflpr_pkg::lflpr_sts_t sts_i,
  output lflpr_pkg::lflpr_cmd_t cmd_o
);
  import lflpr_pkg::*;

  lflpr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.is_clear || (sts_i.scan_done && !sts_i.rd_pend)) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.scan_rd = !sts_i.scan_done;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a scan always ends in a commit, never straight back to idle
  a_scan_to_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |=> state_q != ST_IDLE)
    else $error("scan left without commit");

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("commit while output word still held");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !cmd_o.scan_rd && !cmd_o.commit)
    else $error("table activity while idle");

endmodule

### hw/rtl/lflpr_dp.sv
// datapath: frame table, scan accumulators, counters and result register
module lflpr_dp #(
  parameter int unsigned TABLE_FRAMES = 64,
  parameter int unsigned PROC_BITS    = 8,
  parameter int unsigned PAGE_BITS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lflpr_pkg::lflpr_cmd_t             cmd_i,
  output lflpr_pkg::lflpr_sts_t             sts_o,
  input  logic                              cfg_we_i,
  input  logic [lflpr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lflpr_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                              cmd_in_i,
  input  logic [PROC_BITS-1:0]              proc_id_i,
  input  logic [PAGE_BITS-1:0]              page_num_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic                              replaced_o,
  output logic [lflpr_pkg::FIDX_W-1:0]      frame_index_o,
  output logic [lflpr_pkg::FAULT_W-1:0]     fault_total_o,
  output logic                              overflow_o
);
  import lflpr_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_FRAMES);
  localparam int unsigned CNT_W  = $clog2(TABLE_FRAMES + 1);
  localparam int unsigned CMP_W  = (CNT_W > QUOTA_W) ? CNT_W : QUOTA_W;
  localparam int unsigned XIDX_W = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;
  localparam int unsigned WORD_W = PROC_BITS + PAGE_BITS + 2 * TIME_W;
  localparam int unsigned PROC_LO = PAGE_BITS + 2 * TIME_W;
  localparam int unsigned PAGE_LO = 2 * TIME_W;
  localparam int unsigned LOAD_LO = TIME_W;

  // configuration
  logic [QUOTA_W-1:0] quota_q;
  logic               policy_q;

  // captured word
  logic                 cmd_q;
  logic [PROC_BITS-1:0] proc_q;
  logic [PAGE_BITS-1:0] page_q;

  // scan
  logic [CNT_W-1:0]  cnt_q;
  logic              rd_pend_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [CNT_W-1:0]  owned_q;
  logic              found_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [TIME_W-1:0] hit_loaded_q;
  logic              have_vic_q;
  logic [TIME_W-1:0] best_q;
  logic [IDX_W-1:0]  vic_idx_q;

  // table state
  logic [CNT_W-1:0]   used_q;
  logic [TIME_W-1:0]  clock_q;
  logic [FAULT_W-1:0] fault_q;

  // result register
  logic               out_valid_q;
  logic               hit_q, replaced_q, ovf_q;
  logic [FIDX_W-1:0]  fidx_q;
  logic [FAULT_W-1:0] ftotal_q;

  // ram ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  lflpr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_FRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // entry fields of the word read last cycle
  logic [PROC_BITS-1:0] r_proc;
  logic [PAGE_BITS-1:0] r_page;
  logic [TIME_W-1:0]    r_loaded, r_used, r_time;
  logic                 r_mine, r_better;

  assign r_proc   = ram_rdata[PROC_LO +: PROC_BITS];
  assign r_page   = ram_rdata[PAGE_LO +: PAGE_BITS];
  assign r_loaded = ram_rdata[LOAD_LO +: TIME_W];
  assign r_used   = ram_rdata[0 +: TIME_W];
  assign r_time   = (policy_q == POLICY_LRU) ? r_used : r_loaded;
  assign r_mine   = rd_pend_q && (r_proc == proc_q);
  assign r_better = !have_vic_q || (r_time < best_q);

  // commit decision
  logic              at_quota, room;
  logic [IDX_W-1:0]  res_idx;
  logic [XIDX_W-1:0] res_idx_x;
  logic              res_hit, res_rep, res_ovf;
  logic [FAULT_W-1:0] fault_inc;

  assign at_quota = (owned_q != '0) && (CMP_W'(owned_q) >= CMP_W'(quota_q));
  assign room     = (used_q != CNT_W'(TABLE_FRAMES));
  assign fault_inc = (fault_q != '1) ? fault_q + FAULT_W'(1) : fault_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = {proc_q, page_q, clock_q, clock_q};
    res_idx   = '0;
    res_hit   = 1'b0;
    res_rep   = 1'b0;
    res_ovf   = 1'b0;
    if (found_q) begin
      res_hit   = 1'b1;
      res_idx   = hit_idx_q;
      ram_we    = cmd_i.commit && (cmd_q == CMD_REF) && (policy_q == POLICY_LRU);
      ram_wdata = {proc_q, page_q, hit_loaded_q, clock_q};
    end else if (at_quota) begin
      res_rep   = 1'b1;
      res_idx   = vic_idx_q;
      ram_waddr = vic_idx_q;
      ram_we    = cmd_i.commit && (cmd_q == CMD_REF);
    end else if (room) begin
      res_idx   = used_q[IDX_W-1:0];
      ram_waddr = used_q[IDX_W-1:0];
      ram_we    = cmd_i.commit && (cmd_q == CMD_REF);
    end else begin
      res_ovf = 1'b1;
    end
  end

  assign res_idx_x = XIDX_W'(res_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quota_q     <= QUOTA_RESET;
      policy_q    <= POLICY_FIFO;
      rd_pend_q   <= 1'b0;
      used_q      <= '0;
      clock_q     <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FRAMES_PER_PROCESS: quota_q  <= cfg_wdata_i;
          CFG_POLICY_MODE:        policy_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      rd_pend_q <= cmd_i.scan_rd;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (cmd_q == CMD_CLEAR) begin
          used_q  <= '0;
          clock_q <= '0;
          fault_q <= '0;
        end else begin
          clock_q <= clock_q + TIME_W'(1);
          if (!found_q) begin
            fault_q <= fault_inc;
            if (!at_quota && room) begin
              used_q <= used_q + CNT_W'(1);
            end
          end
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= cmd_in_i;
      proc_q     <= proc_id_i;
      page_q     <= page_num_i;
      cnt_q      <= '0;
      owned_q    <= '0;
      found_q    <= 1'b0;
      have_vic_q <= 1'b0;
    end else begin
      if (cmd_i.scan_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (r_mine) begin
        owned_q <= owned_q + CNT_W'(1);
        if (!found_q && (r_page == page_q)) begin
          found_q      <= 1'b1;
          hit_idx_q    <= rd_idx_q;
          hit_loaded_q <= r_loaded;
        end
        if (r_better) begin
          have_vic_q <= 1'b1;
          best_q     <= r_time;
          vic_idx_q  <= rd_idx_q;
        end
      end
    end
    rd_idx_q <= cnt_q[IDX_W-1:0];
    if (cmd_i.commit) begin
      if (cmd_q == CMD_CLEAR) begin
        hit_q      <= 1'b0;
        replaced_q <= 1'b0;
        fidx_q     <= '0;
        ftotal_q   <= '0;
        ovf_q      <= 1'b0;
      end else begin
        hit_q      <= res_hit;
        replaced_q <= res_rep;
        fidx_q     <= res_idx_x[FIDX_W-1:0];
        ftotal_q   <= found_q ? fault_q : fault_inc;
        ovf_q      <= res_ovf;
      end
    end
  end

  assign sts_o.is_clear  = (cmd_q == CMD_CLEAR);
  assign sts_o.scan_done = (cnt_q == used_q);
  assign sts_o.rd_pend   = rd_pend_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign replaced_o    = replaced_q;
  assign frame_index_o = fidx_q;
  assign fault_total_o = ftotal_q;
  assign overflow_o    = ovf_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_FRAMES))
    else $error("frame count beyond table size");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (CNT_W'(rd_idx_q) < used_q))
    else $error("scan read beyond filled frames");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && cmd_q == CMD_CLEAR |=> fault_q == '0 && used_q == '0 && clock_q == '0)
    else $error("clear left state behind");

  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && cmd_q == CMD_REF && found_q |=> $stable(fault_q) && $stable(used_q))
    else $error("hit changed fault count or table size");

endmodule

### hw/rtl/local_fifo_lru_page_replacer.sv
// top level of the local-allocation fifo/lru page replacer
//
// input channel (in_valid_i / in_stall_o) carries one word per page reference
// or clear command; the result channel (out_valid_o / out_stall_i) returns
// exactly one word for each input word, in order.
// configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 frames per process, 1 policy: 0 fifo, 1 lru); write only while idle.
// a reference reads every filled frame from the table ram once, one frame a
// cycle, and is committed once the last read word is checked; a clear
// leaves the scan step without reading the table. one word is in work at a
// time; a new word is accepted once the previous one is committed to the
// result register, even while that result is still waiting.
// if the receiver stalls, the result word holds and the next word waits in
// the commit step until the result register is free.
// reset empties the table (no clearing pass), zeroes the reference clock and
// fault count, and sets the quota to 4 and the policy to fifo.
module local_fifo_lru_page_replacer #(
  parameter int unsigned TABLE_FRAMES = 64,
  parameter int unsigned PROC_BITS    = 8,
  parameter int unsigned PAGE_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lflpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lflpr_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [PROC_BITS-1:0]            proc_id_i,
  input  logic [PAGE_BITS-1:0]            page_num_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic                            replaced_o,
  output logic [lflpr_pkg::FIDX_W-1:0]    frame_index_o,
  output logic [lflpr_pkg::FAULT_W-1:0]   fault_total_o,
  output logic                            overflow_o
);
  import lflpr_pkg::*;

  lflpr_cmd_t ctrl_cmd;
  lflpr_sts_t dp_sts;

  lflpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  lflpr_dp #(
    .TABLE_FRAMES (TABLE_FRAMES),
    .PROC_BITS    (PROC_BITS),
    .PAGE_BITS    (PAGE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .sts_o         (dp_sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_in_i      (cmd_i),
    .proc_id_i     (proc_id_i),
    .page_num_i    (page_num_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .replaced_o    (replaced_o),
    .frame_index_o (frame_index_o),
    .fault_total_o (fault_total_o),
    .overflow_o    (overflow_o)
  );

endmodule

### tb/testbench.sv
// testbench of the local fifo/lru page replacer: directed table, random phases, predictor check
`timescale 1ns / 1ps

module testbench;
  import lflpr_pkg::*;

  localparam int unsigned FRAMES = 64;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic                 hit;
    logic                 replaced;
    logic [FIDX_W-1:0]    frame_index;
    logic [FAULT_W-1:0]   fault_total;
    logic                 overflow;
  } outcome_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic               cmd;
    logic [7:0]         proc;
    logic [15:0]        page;
    bit                 typed;
    outcome_t           want;
    logic [QUOTA_W-1:0] quota;
    logic               pol;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 cmd_i;
  logic [7:0]           proc_id_i;
  logic [15:0]          page_num_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 hit_o;
  logic                 replaced_o;
  logic [FIDX_W-1:0]    frame_index_o;
  logic [FAULT_W-1:0]   fault_total_o;
  logic                 overflow_o;

  local_fifo_lru_page_replacer #(
    .TABLE_FRAMES(FRAMES),
    .PROC_BITS   (8),
    .PAGE_BITS   (16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .proc_id_i    (proc_id_i),
    .page_num_i   (page_num_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .replaced_o   (replaced_o),
    .frame_index_o(frame_index_o),
    .fault_total_o(fault_total_o),
    .overflow_o   (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // predictor copy of the frame table and registers
  logic [7:0]         tab_proc   [FRAMES];
  logic [15:0]        tab_page   [FRAMES];
  logic [31:0]        tab_loaded [FRAMES];
  logic [31:0]        tab_used   [FRAMES];
  int unsigned        tab_fill;
  logic [31:0]        ref_time;
  logic [31:0]        fault_count;
  logic [QUOTA_W-1:0] quota_now;
  logic               policy_now;

  outcome_t    pending_outcomes[$];
  script_row_t script[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned words_sent;
  int unsigned clears_sent;
  int unsigned hits_seen;
  int unsigned replaced_seen;
  int unsigned overflow_seen;
  int unsigned cycle_cnt;
  logic        calm;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // window where neither side idles
  assign calm = (cycle_cnt >= 3000) && (cycle_cnt < 6000);

  function automatic outcome_t make_outcome(int unsigned h, int unsigned r, int unsigned idx,
                                            int unsigned faults, int unsigned ovf);
    outcome_t o;
    o.hit         = h[0];
    o.replaced    = r[0];
    o.frame_index = idx[FIDX_W-1:0];
    o.fault_total = faults;
    o.overflow    = ovf[0];
    return o;
  endfunction

  function automatic outcome_t lookup_page(logic cmd, logic [7:0] proc, logic [15:0] page);
    outcome_t    res;
    logic [31:0] now;
    logic [31:0] best;
    logic [31:0] stamp;
    int unsigned owned;
    int unsigned victim;
    int unsigned slot;
    int unsigned i;
    bit          found;
    bit          have;
    res    = '0;
    owned  = 0;
    victim = 0;
    slot   = 0;
    found  = 1'b0;
    have   = 1'b0;
    best   = '0;
    if (cmd == CMD_CLEAR) begin
      tab_fill    = 0;
      ref_time    = '0;
      fault_count = '0;
      return res;
    end
    now      = ref_time;
    ref_time = now + 32'd1;
    for (i = 0; i < tab_fill; i++) begin
      if (tab_proc[i] == proc) begin
        owned++;
        if (!found && tab_page[i] == page) begin
          found = 1'b1;
          slot  = i;
        end
        stamp = (policy_now == POLICY_LRU) ? tab_used[i] : tab_loaded[i];
        if (!have || stamp < best) begin
          have   = 1'b1;
          best   = stamp;
          victim = i;
        end
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (policy_now == POLICY_LRU) tab_used[slot] = now;
    end else begin
      if (fault_count != 32'hFFFF_FFFF) fault_count = fault_count + 32'd1;
      if (owned > 0 && owned >= quota_now) begin
        slot         = victim;
        res.replaced = 1'b1;
      end else if (tab_fill < FRAMES) begin
        slot = tab_fill;
        tab_fill++;
      end else begin
        res.overflow = 1'b1;
        slot         = 0;
      end
      if (!res.overflow) begin
        tab_proc[slot]   = proc;
        tab_page[slot]   = page;
        tab_loaded[slot] = now;
        tab_used[slot]   = now;
      end
    end
    res.frame_index = slot[FIDX_W-1:0];
    res.fault_total = fault_count;
    return res;
  endfunction

  function automatic void add_word(logic cmd, logic [7:0] proc, logic [15:0] page,
                                   bit typed, outcome_t want);
    script_row_t row;
    row.kind  = ROW_WORD;
    row.cmd   = cmd;
    row.proc  = proc;
    row.page  = page;
    row.typed = typed;
    row.want  = want;
    row.quota = '0;
    row.pol   = 1'b0;
    script    = {script, row};
  endfunction

  function automatic void add_cfg(logic [QUOTA_W-1:0] q, logic pol);
    script_row_t row;
    row.kind  = ROW_CFG;
    row.cmd   = CMD_REF;
    row.proc  = '0;
    row.page  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    row.quota = q;
    row.pol   = pol;
    script    = {script, row};
  endfunction

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic [QUOTA_W-1:0] q, logic pol);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_FRAMES_PER_PROCESS;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    cfg_index_i <= CFG_POLICY_MODE;
    cfg_wdata_i <= {{(CFG_W-1){1'b0}}, pol};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    quota_now  = q;
    policy_now = pol;
  endtask

  task automatic send_word(logic cmd, logic [7:0] proc, logic [15:0] page,
                           bit typed, outcome_t want);
    outcome_t pred;
    if (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    proc_id_i  <= proc;
    page_num_i <= page;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = lookup_page(cmd, proc, page);
    pending_outcomes = {pending_outcomes, (typed ? want : pred)};
    words_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  task automatic send_random(logic cmd, logic [7:0] proc, logic [15:0] page);
    send_word(cmd, proc, page, 1'b0, '0);
  endtask

  // one table of references that runs past the 64-frame limit
  task automatic fill_phase();
    logic [7:0]  owner;
    logic [7:0]  other;
    logic [15:0] base;
    int          k;
    owner = 8'($urandom);
    other = owner ^ 8'h5A;
    base  = 16'($urandom);
    set_config(7'd127, POLICY_LRU);
    send_random(CMD_CLEAR, 8'($urandom), 16'($urandom));
    for (k = 0; k < FRAMES + 2; k++) send_random(CMD_REF, owner, base + 16'(k));
    for (k = 0; k < 4; k++) send_random(CMD_REF, other, 16'($urandom));
    for (k = 0; k < 10; k++)
      send_random(CMD_REF, owner, base + 16'($urandom_range(FRAMES - 1)));
  endtask

  task automatic mixed_phase(int idx);
    logic [QUOTA_W-1:0] q;
    logic               pol;
    logic [7:0]         procs[4];
    logic [15:0]        base;
    int                 nproc;
    int                 span;
    int                 k;
    int                 r;
    case (idx)
      0:       q = 7'd1;
      2:       q = 7'd0;
      3:       q = 7'd64;
      4:       q = 7'd2;
      default: q = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(6));
    endcase
    pol = (idx < 5) ? logic'(idx[0]) : logic'($urandom_range(1));
    set_config(q, pol);
    for (k = 0; k < 4; k++) procs[k] = 8'($urandom);
    nproc = $urandom_range(1, 4);
    span  = 2 << $urandom_range(3);
    base  = 16'($urandom);
    if ($urandom_range(1)) send_random(CMD_CLEAR, 8'($urandom), 16'($urandom));
    for (k = 0; k < 35; k++) begin
      r = $urandom_range(99);
      if (r < 4)
        send_random(CMD_CLEAR, 8'($urandom), 16'($urandom));
      else if (r < 12)
        send_random(CMD_REF, 8'($urandom), 16'($urandom));
      else
        send_random(CMD_REF, procs[$urandom_range(nproc - 1)],
                    base + 16'($urandom_range(span - 1)));
    end
  endtask

  // stimulus
  initial begin
    int          phase;
    script_row_t row;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_REF;
    proc_id_i   = '0;
    page_num_i  = '0;
    tab_fill    = 0;
    ref_time    = '0;
    fault_count = '0;
    quota_now   = QUOTA_RESET;
    policy_now  = POLICY_FIFO;
    mismatches  = 0;
    words_sent  = 0;
    clears_sent = 0;

    add_word(CMD_CLEAR, 8'hFF, 16'hFFFF, 1'b1, make_outcome(0, 0, 0, 0, 0));
    add_word(CMD_REF, 8'h00, 16'h0000, 1'b1, make_outcome(0, 0, 0, 1, 0));
    add_word(CMD_REF, 8'h00, 16'h0000, 1'b1, make_outcome(1, 0, 0, 1, 0));
    add_word(CMD_REF, 8'hFF, 16'hFFFF, 1'b1, make_outcome(0, 0, 1, 2, 0));
    add_word(CMD_REF, 8'hFF, 16'hFFFF, 1'b1, make_outcome(1, 0, 1, 2, 0));
    add_word(CMD_REF, 8'h00, 16'h0001, 1'b1, make_outcome(0, 0, 2, 3, 0));
    add_word(CMD_REF, 8'h00, 16'h0002, 1'b1, make_outcome(0, 0, 3, 4, 0));
    add_word(CMD_REF, 8'h00, 16'h0003, 1'b1, make_outcome(0, 0, 4, 5, 0));
    // quota of four reached, fifo evicts the oldest load
    add_word(CMD_REF, 8'h00, 16'h0004, 1'b1, make_outcome(0, 1, 0, 6, 0));
    add_cfg(QUOTA_RESET, POLICY_LRU);
    add_word(CMD_REF, 8'h00, 16'h0001, 1'b0, '0);
    add_word(CMD_REF, 8'h00, 16'h0005, 1'b0, '0);
    add_word(CMD_REF, 8'h00, 16'h0001, 1'b0, '0);
    // zero quota: first reference appends, later misses replace
    add_cfg(7'd0, POLICY_LRU);
    add_word(CMD_REF, 8'h07, 16'h0009, 1'b0, '0);
    add_word(CMD_REF, 8'h07, 16'h000A, 1'b0, '0);
    add_cfg(7'd127, POLICY_FIFO);
    add_word(CMD_REF, 8'h80, 16'h8000, 1'b0, '0);
    add_word(CMD_REF, 8'h80, 16'h7FFF, 1'b0, '0);
    add_word(CMD_CLEAR, 8'h00, 16'h0000, 1'b1, make_outcome(0, 0, 0, 0, 0));
    add_word(CMD_REF, 8'hAA, 16'h5555, 1'b1, make_outcome(0, 0, 0, 1, 0));
    add_cfg(7'd1, POLICY_FIFO);
    add_word(CMD_REF, 8'hAA, 16'h5555, 1'b0, '0);
    add_word(CMD_REF, 8'hAA, 16'hAAAA, 1'b0, '0);
    add_word(CMD_REF, 8'h55, 16'hAAAA, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_CFG) set_config(row.quota, row.pol);
      else send_word(row.cmd, row.proc, row.page, row.typed, row.want);
    end

    phase = 0;
    while (words_sent < 450) begin
      if (phase == 1) fill_phase();
      else mixed_phase(phase);
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("sent %0d words (%0d clears) over %0d phases of quota and policy settings",
             words_sent, clears_sent, phase);
    $display("results: %0d hits, %0d replacements, %0d overflows, %0d mismatches",
             hits_seen, replaced_seen, overflow_seen, mismatches);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver stall, with one long hold-off so the block backs up
  initial begin
    bit held;
    held        = 1'b0;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 120) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 37);
      end
    end
  end

  // result check
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.hit         = hit_o;
      got.replaced    = replaced_o;
      got.frame_index = frame_index_o;
      got.fault_total = fault_total_o;
      got.overflow    = overflow_o;
      results_seen <= results_seen + 1;
      if (hit_o) hits_seen <= hits_seen + 1;
      if (replaced_o) replaced_seen <= replaced_seen + 1;
      if (overflow_o) overflow_seen <= overflow_seen + 1;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %0d: hit=%0b rep=%0b idx=%0d faults=%0d ovf=%0b",
                   results_seen, got.hit, got.replaced, got.frame_index,
                   got.fault_total, got.overflow);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.hit !== want.hit || got.replaced !== want.replaced ||
            got.frame_index !== want.frame_index ||
            got.fault_total !== want.fault_total || got.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word %0d expected hit=%0b rep=%0b idx=%0d faults=%0d ovf=%0b",
                     results_seen, want.hit, want.replaced, want.frame_index,
                     want.fault_total, want.overflow);
            $display("word %0d actual   hit=%0b rep=%0b idx=%0d faults=%0d ovf=%0b",
                     results_seen, got.hit, got.replaced, got.frame_index,
                     got.fault_total, got.overflow);
          end
        end
      end
    end
  end

  initial begin
    results_seen  = 0;
    hits_seen     = 0;
    replaced_seen = 0;
    overflow_seen = 0;
    cycle_cnt     = 0;
  end

  // run limit
  initial begin
    #800000;
    $display("timeout with %0d results outstanding", pending_outcomes.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### local_fifo_lru_page_replacer.f
hw/rtl/lflpr_pkg.sv
hw/rtl/lflpr_ram.sv
hw/rtl/lflpr_ctrl.sv
hw/rtl/lflpr_dp.sv
hw/rtl/local_fifo_lru_page_replacer.sv
tb/testbench.sv
